[rtl/ssbf_pkg.sv]
// Shared types, constants and helper function of the sensor sample batch framer.
package ssbf_pkg;

	localparam logic [10:0] PACKET_BYTES = 11'd42;
	localparam logic [10:0] FIFO_LIMIT = 11'd1024;
	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] RATIO_RESET = 8'd1;
	localparam logic [7:0] COMMAND_RESET = 8'd4;
	localparam logic [3:0] CHUNK_FULL = 4'd8;
	localparam logic [3:0] CHUNK_TAIL = 4'd5;

	// Register select, taken from paddr[2].
	localparam logic REG_DEC_RATIO = 1'b0;
	localparam logic REG_FRAME_CMD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH_RD,
		ST_CHUNK,
		ST_DECIM
	} ssbf_state_t;

	typedef struct packed {
		logic init;
		logic step;
	} ssbf_fu_ctrl_t;

	function automatic logic [7:0] xor_fold(input logic [63:0] row);
		logic [7:0] acc;
		acc = 8'd0;
		for (int i = 0; i < 8; i++) begin
			acc = acc ^ row[8*i +: 8];
		end
		return acc;
	endfunction

endpackage

[rtl/ssbf_store.sv]
// Sample store: one 64-bit row per sample, one write port and one registered read port.
module ssbf_store #(
	parameter int SAMPLES = 10,
	parameter int ROW_AW = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ROW_AW-1:0] wr_addr,
	input  logic [63:0]       wr_data,
	input  logic              rd_en,
	input  logic [ROW_AW-1:0] rd_addr,
	output logic [63:0]       rd_data
);

	logic [63:0] mem [SAMPLES];
	logic [63:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/ssbf_frame_unit.sv]
// Frame datapath: builds each chunk (8 bytes, 5 for the checksum chunk) and folds the XOR checksum row by row.
module ssbf_frame_unit #(
	parameter int SAMPLES = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssbf_pkg::ssbf_fu_ctrl_t ctrl,
	input  logic [3:0]             chunk_idx,
	input  logic [63:0]            row_data,
	input  logic [7:0]             frame_command,
	output logic [63:0]            chunk_data,
	output logic [3:0]             chunk_len,
	output logic                   chunk_last
);
	import ssbf_pkg::*;

	localparam logic [15:0] PayloadLen = 16'(8 * SAMPLES);
	localparam logic [3:0] LastIdx = 4'(SAMPLES);

	logic [7:0]  acc_q;
	logic [31:0] prev_q;
	logic [31:0] header;

	assign header = {PayloadLen[15:8], PayloadLen[7:0], frame_command, START_BYTE};

	// The running checksum starts from the four header bytes and takes one row per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
		end else if (ctrl.init) begin
			acc_q <= START_BYTE ^ frame_command ^ PayloadLen[15:8] ^ PayloadLen[7:0];
		end else if (ctrl.step) begin
			acc_q <= acc_q ^ xor_fold(row_data);
		end
	end

	// The upper half of a row spills into the next chunk, since the header shifts it by four.
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			prev_q <= row_data[63:32];
		end
	end

	always_comb begin
		priority if (chunk_idx == LastIdx) begin
			chunk_data = {24'd0, acc_q, prev_q};
			chunk_len  = CHUNK_TAIL;
			chunk_last = 1'b1;
		end else if (chunk_idx == 4'd0) begin
			chunk_data = {row_data[31:0], header};
			chunk_len  = CHUNK_FULL;
			chunk_last = 1'b0;
		end else begin
			chunk_data = {row_data[31:0], prev_q};
			chunk_len  = CHUNK_FULL;
			chunk_last = 1'b0;
		end
	end

endmodule

[rtl/sensor_sample_batch_framer_core.sv]
// Top level of the sensor sample batch framer: sequencer, registers and output stage.
//
//   port group  | direction | beat contents
//   s_*         | in        | one sensor packet event
//   m_*         | out       | one frame chunk, tlast on the checksum chunk
//   APB         | in/out    | decimation_ratio at 0x0, frame_command at 0x4
//
// A rejected event leaves the sequencer idle; a kept or skipped event passes the decimation step.
// An event that finds the store full runs one store read to start, then one chunk per cycle
// while m_tready stays high, then the decimation step.
// The chunk rate is set by the single read port of the sample store and the output register.
// s_tready is low while an event is in work; a low m_tready holds the sequencer in the chunk state.
// Reset clears the counters, registers and output valid; the store holds no reset value.
module sensor_sample_batch_framer_core #(
	parameter int SAMPLES = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// fifo_count[10:0], quat_w[42:11], quat_x[74:43], quat_y[106:75], quat_z[138:107], zeros
	input  logic [143:0] s_tdata,
	// overflow_flag[0], ready_flag[1]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// chunk_bytes[63:0], chunk_length[67:64], zeros
	output logic [71:0]  m_tdata,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import ssbf_pkg::*;

	localparam int RowAw = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [3:0] SampleMax = 4'(SAMPLES);

	ssbf_state_t    state_q, state_d;
	ssbf_fu_ctrl_t  fu_ctrl;

	logic [7:0]  ratio_q, command_q;
	logic [3:0]  sample_count_q;
	logic [7:0]  dec_count_q;
	logic [3:0]  chunk_idx_q;
	logic [63:0] row_q;

	logic        in_beat, event_ok, out_free, out_load;
	logic        rd_en, wr_en;
	logic [3:0]  rd_row;
	logic [3:0]  next_idx;
	logic [63:0] rd_data;
	logic [63:0] chunk_data;
	logic [3:0]  chunk_len;
	logic        chunk_last;

	logic        m_tvalid_q, m_tlast_q;
	logic [63:0] m_bytes_q;
	logic [3:0]  m_len_q;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q   <= RATIO_RESET;
			command_q <= COMMAND_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_DEC_RATIO: ratio_q   <= pwdata[7:0];
				REG_FRAME_CMD: command_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEC_RATIO: prdata = {24'd0, ratio_q};
			REG_FRAME_CMD: prdata = {24'd0, command_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Event qualification.
	assign in_beat  = s_tvalid && s_tready;
	assign event_ok = (s_tdata[10:0] >= PACKET_BYTES) && (s_tdata[10:0] < FIFO_LIMIT)
		&& !s_tuser[0] && s_tuser[1];

	assign out_free = !m_tvalid_q || m_tready;
	assign next_idx = chunk_idx_q + 4'd1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat && event_ok) begin
					state_d = (sample_count_q == SampleMax) ? ST_FLUSH_RD : ST_DECIM;
				end
			end
			ST_FLUSH_RD: state_d = ST_CHUNK;
			ST_CHUNK: begin
				if (out_free && chunk_idx_q == SampleMax) begin
					state_d = ST_DECIM;
				end
			end
			ST_DECIM: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready     = 1'b0;
		fu_ctrl.init = 1'b0;
		fu_ctrl.step = 1'b0;
		out_load     = 1'b0;
		rd_en        = 1'b0;
		rd_row       = 4'd0;
		wr_en        = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_FLUSH_RD: begin
				fu_ctrl.init = 1'b1;
				rd_en        = 1'b1;
			end
			ST_CHUNK: begin
				if (out_free) begin
					out_load     = 1'b1;
					fu_ctrl.step = (chunk_idx_q != SampleMax);
					rd_en        = (next_idx < SampleMax);
					rd_row       = next_idx;
				end
			end
			ST_DECIM: wr_en = (dec_count_q == ratio_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= 4'd0;
			dec_count_q    <= 8'd0;
			chunk_idx_q    <= 4'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FLUSH_RD) begin
				sample_count_q <= 4'd0;
				chunk_idx_q    <= 4'd0;
			end else if (out_load && chunk_idx_q != SampleMax) begin
				// The index rests on the checksum chunk until the next flush.
				chunk_idx_q <= next_idx;
			end
			if (state_q == ST_DECIM) begin
				if (wr_en) begin
					dec_count_q    <= 8'd0;
					sample_count_q <= sample_count_q + 4'd1;
				end else begin
					dec_count_q <= dec_count_q + 8'd1;
				end
			end
		end
	end

	// Upper 16 bits of w, x, y, z in big-endian byte order, first byte lowest.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			row_q <= {s_tdata[130:123], s_tdata[138:131], s_tdata[98:91], s_tdata[106:99],
				s_tdata[66:59], s_tdata[74:67], s_tdata[34:27], s_tdata[42:35]};
		end
	end

	ssbf_store #(
		.SAMPLES(SAMPLES),
		.ROW_AW (RowAw)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(sample_count_q[RowAw-1:0]),
		.wr_data(row_q),
		.rd_en  (rd_en),
		.rd_addr(rd_row[RowAw-1:0]),
		.rd_data(rd_data)
	);

	ssbf_frame_unit #(
		.SAMPLES(SAMPLES)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (fu_ctrl),
		.chunk_idx    (chunk_idx_q),
		.row_data     (rd_data),
		.frame_command(command_q),
		.chunk_data   (chunk_data),
		.chunk_len    (chunk_len),
		.chunk_last   (chunk_last)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_bytes_q <= chunk_data;
			m_len_q   <= chunk_len;
			m_tlast_q <= chunk_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, m_len_q, m_bytes_q};
	assign m_tlast  = m_tlast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count_q <= SampleMax)
		else $error("sample count beyond store size");

	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_idx_q <= SampleMax)
		else $error("chunk index beyond frame end");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH_RD |=> sample_count_q == 4'd0 && chunk_idx_q == 4'd0)
		else $error("flush did not clear the counters");

	a_tail_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && chunk_last |=> m_tvalid && m_tlast && m_tdata[67:64] == CHUNK_TAIL)
		else $error("checksum chunk with wrong length");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHUNK |-> !s_tready)
		else $error("input taken while a frame is emitted");

endmodule
